// ===== hdl/sc1a_pkg.sv =====
// sc1a_pkg: shared types, scancode constants and the three character roms
// for the set-1 scancode to ascii translator.
// No dependencies.
`timescale 1ns / 1ps

package sc1a_pkg;

	// raw byte codes
	localparam logic [7:0] PREFIX_BYTE = 8'hE0;
	localparam int         RELEASE_BIT = 7;
	localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
	localparam logic [6:0] KEY_RSHIFT  = 7'h36;
	localparam logic [6:0] KEY_CAPS    = 7'h3A;
	localparam logic [6:0] KEY_ALT     = 7'h38;
	localparam logic [6:0] CH_ESC      = 7'h1B;
	localparam logic [6:0] CH_NONE     = 7'h00;

	// keyboard modifier state carried between items
	typedef struct packed {
		logic shift_held;
		logic caps_on;
		logic altgr_held;
		logic prefix_seen;
	} kbd_flags_t;

	// outcome of decoding one scancode item
	typedef struct packed {
		kbd_flags_t flags;
		logic       emit;
		logic [6:0] ch;
	} decode_t;

	// unshifted map
	function automatic logic [6:0] rom_normal(input logic [6:0] key);
		logic [6:0] c;
		case (key)
			7'h01: c = CH_ESC;
			7'h02: c = 7'h31;
			7'h03: c = 7'h32;
			7'h04: c = 7'h33;
			7'h05: c = 7'h34;
			7'h06: c = 7'h35;
			7'h07: c = 7'h36;
			7'h08: c = 7'h37;
			7'h09: c = 7'h38;
			7'h0A: c = 7'h39;
			7'h0B: c = 7'h30;
			7'h0C: c = 7'h27;
			7'h0E: c = 7'h08;
			7'h0F: c = 7'h09;
			7'h10: c = 7'h71;
			7'h11: c = 7'h77;
			7'h12: c = 7'h65;
			7'h13: c = 7'h72;
			7'h14: c = 7'h74;
			7'h15: c = 7'h79;
			7'h16: c = 7'h75;
			7'h17: c = 7'h69;
			7'h18: c = 7'h6F;
			7'h19: c = 7'h70;
			7'h1A: c = 7'h60;
			7'h1B: c = 7'h2B;
			7'h1C: c = 7'h0A;
			7'h1E: c = 7'h61;
			7'h1F: c = 7'h73;
			7'h20: c = 7'h64;
			7'h21: c = 7'h66;
			7'h22: c = 7'h67;
			7'h23: c = 7'h68;
			7'h24: c = 7'h6A;
			7'h25: c = 7'h6B;
			7'h26: c = 7'h6C;
			7'h27: c = 7'h6E;
			7'h2B: c = 7'h63;
			7'h2C: c = 7'h7A;
			7'h2D: c = 7'h78;
			7'h2E: c = 7'h63;
			7'h2F: c = 7'h76;
			7'h30: c = 7'h62;
			7'h31: c = 7'h6E;
			7'h32: c = 7'h6D;
			7'h33: c = 7'h2C;
			7'h34: c = 7'h2E;
			7'h35: c = 7'h2D;
			7'h39: c = 7'h20;
			7'h56: c = 7'h3C;
			default: c = CH_NONE;
		endcase
		return c;
	endfunction

	// shifted map
	function automatic logic [6:0] rom_shift(input logic [6:0] key);
		logic [6:0] c;
		case (key)
			7'h01: c = CH_ESC;
			7'h02: c = 7'h21;
			7'h03: c = 7'h22;
			7'h05: c = 7'h24;
			7'h06: c = 7'h25;
			7'h07: c = 7'h26;
			7'h08: c = 7'h2F;
			7'h09: c = 7'h28;
			7'h0A: c = 7'h29;
			7'h0B: c = 7'h3D;
			7'h0C: c = 7'h3F;
			7'h0E: c = 7'h08;
			7'h0F: c = 7'h09;
			7'h10: c = 7'h51;
			7'h11: c = 7'h57;
			7'h12: c = 7'h45;
			7'h13: c = 7'h52;
			7'h14: c = 7'h54;
			7'h15: c = 7'h59;
			7'h16: c = 7'h55;
			7'h17: c = 7'h49;
			7'h18: c = 7'h4F;
			7'h19: c = 7'h50;
			7'h1A: c = 7'h5E;
			7'h1B: c = 7'h2A;
			7'h1C: c = 7'h0A;
			7'h1E: c = 7'h41;
			7'h1F: c = 7'h53;
			7'h20: c = 7'h44;
			7'h21: c = 7'h46;
			7'h22: c = 7'h47;
			7'h23: c = 7'h48;
			7'h24: c = 7'h4A;
			7'h25: c = 7'h4B;
			7'h26: c = 7'h4C;
			7'h2C: c = 7'h5A;
			7'h2D: c = 7'h58;
			7'h2E: c = 7'h43;
			7'h2F: c = 7'h56;
			7'h30: c = 7'h42;
			7'h31: c = 7'h4E;
			7'h32: c = 7'h4D;
			7'h33: c = 7'h3B;
			7'h34: c = 7'h3A;
			7'h35: c = 7'h5F;
			7'h39: c = 7'h20;
			7'h56: c = 7'h3E;
			default: c = CH_NONE;
		endcase
		return c;
	endfunction

	// altgr map
	function automatic logic [6:0] rom_altgr(input logic [6:0] key);
		logic [6:0] c;
		case (key)
			7'h02: c = 7'h7C;
			7'h03: c = 7'h40;
			7'h04: c = 7'h23;
			7'h05: c = 7'h7E;
			7'h1A: c = 7'h5B;
			7'h1B: c = 7'h5D;
			7'h28: c = 7'h7B;
			7'h29: c = 7'h5C;
			7'h2B: c = 7'h7D;
			default: c = CH_NONE;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/sc1a_decode.sv =====
// sc1a_decode: combinational decode of one scancode byte against the
// current modifier flags. Gives the next flags and the character, if any.
// Depends on sc1a_pkg.
`timescale 1ns / 1ps

module sc1a_decode
	import sc1a_pkg::*;
(
	input  logic [7:0] code,
	input  kbd_flags_t flags,
	output decode_t    dec
);

	logic [6:0] key;
	logic       rel;
	logic [6:0] c_normal;
	logic [6:0] c_shift;
	logic [6:0] c_sel;

	assign key = code[6:0];
	assign rel = code[RELEASE_BIT];

	// rom lookups with caps applied to letters
	always_comb begin
		c_normal = rom_normal(key);
		c_shift  = rom_shift(key);
		if (flags.caps_on && c_normal >= 7'h61 && c_normal <= 7'h7A) begin
			c_normal = c_normal ^ 7'h20;
		end
		if (flags.caps_on && c_shift >= 7'h41 && c_shift <= 7'h5A) begin
			c_shift = c_shift ^ 7'h20;
		end
		if (flags.altgr_held) begin
			c_sel = rom_altgr(key);
		end else if (flags.shift_held) begin
			c_sel = c_shift;
		end else begin
			c_sel = c_normal;
		end
	end

	// flag updates and emit decision
	always_comb begin
		dec.flags = flags;
		dec.emit  = 1'b0;
		dec.ch    = c_sel;
		if (code == PREFIX_BYTE) begin
			dec.flags.prefix_seen = 1'b1;
		end else begin
			dec.flags.prefix_seen = 1'b0;
			if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
				dec.flags.shift_held = ~rel;
			end else if (key == KEY_ALT) begin
				if (flags.prefix_seen) begin
					dec.flags.altgr_held = ~rel;
				end
			end else if (!rel) begin
				if (key == KEY_CAPS) begin
					dec.flags.caps_on = ~flags.caps_on;
				end else begin
					dec.emit = (c_sel != CH_NONE);
				end
			end
		end
	end

endmodule

// ===== hdl/scancode_set1_to_ascii.sv =====
// scancode_set1_to_ascii: top level of the set-1 scancode to ascii translator.
// Depends on sc1a_pkg and sc1a_decode.
`timescale 1ns / 1ps

// Takes one raw set-1 scancode byte per item and gives at most one 7-bit
// ascii character per item (Spanish layout, with shift, caps lock and AltGr).
// Prefix bytes, modifier keys, releases and keys with no character give no
// output item. Each item passes an input register, then flag update and rom
// lookup into the output register, so a byte can be taken every cycle unless
// the input side is held off, and its character is offered on the output
// from the output register. The input side is held off only while a character
// waits, stalled, in the output register and the byte in the input register
// also gives a character.
module scancode_set1_to_ascii
	import sc1a_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       scan_valid,
	output logic       scan_stall,
	input  logic [7:0] scan_code,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [6:0] ascii_char
);

	logic       valid_s1;
	logic [7:0] code_s1;
	kbd_flags_t flags_q;
	decode_t    dec;
	logic       out_free;
	logic       go_s1;
	logic       valid_s2;
	logic [6:0] char_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!scan_stall) begin
			valid_s1 <= scan_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_valid && !scan_stall) begin
			code_s1 <= scan_code;
		end
	end

	// decode against current modifier flags
	sc1a_decode u_decode (
		.code  (code_s1),
		.flags (flags_q),
		.dec   (dec)
	);

	// stage 1 moves on unless it has a character and the output is full
	assign out_free   = !valid_s2 || !char_stall;
	assign go_s1      = valid_s1 && (!dec.emit || out_free);
	assign scan_stall = valid_s1 && !go_s1;

	// modifier flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (go_s1) begin
			flags_q <= dec.flags;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= go_s1 && dec.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && go_s1 && dec.emit) begin
			char_s2 <= dec.ch;
		end
	end

	assign char_valid = valid_s2;
	assign ascii_char = char_s2;

endmodule

// ===== tb/tb_scancode_set1_to_ascii.sv =====
// tb_scancode_set1_to_ascii: self-checking bench for the set-1 scancode translator.
// Predicts each character from its own keyboard state and layout maps, then compares
// the characters that come out. Depends on sc1a_pkg and scancode_set1_to_ascii.
`timescale 1ns / 1ps

module tb_scancode_set1_to_ascii
	import sc1a_pkg::*;
();

	localparam int RANDOM_ITEMS = 850;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 250;
	localparam int DRAIN_CYCLES = 8;

	typedef enum int {MAP_PLAIN = 0, MAP_SHIFT = 1, MAP_ALTGR = 2} layout_map_t;
	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       scan_valid = 1'b0;
	logic       scan_stall;
	logic [7:0] scan_code = 8'h00;
	logic       char_valid;
	logic       char_stall = 1'b0;
	logic [6:0] ascii_char;

	// bench-side keyboard state and layout
	kbd_flags_t  kb = '0;
	logic [7:0]  char_maps [3][128];
	logic [7:0]  keystroke_bytes [$];
	logic [6:0]  expected_chars [$];

	int       bytes_taken = 0;
	int       total_bytes = 0;
	int       error_count = 0;
	int       cycle_count = 0;
	int       burst_left = 0;
	int       gap_left = 0;
	int       mode_left = 0;
	rx_mode_t rx_mode = RX_FREE;
	int       hold_left = 0;
	logic     hold_started = 1'b0;

	scancode_set1_to_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_valid(scan_valid),
		.scan_stall(scan_stall),
		.scan_code (scan_code),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.ascii_char(ascii_char)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// lay a run of consecutive characters into one map
	function automatic void lay_keys(input layout_map_t m, input int first, input string s);
		for (int i = 0; i < s.len(); i++)
			char_maps[m][first + i] = s[i];
	endfunction

	// spanish layout, unshifted, shifted and altgr
	function automatic void build_layout();
		for (int m = 0; m < 3; m++)
			for (int k = 0; k < 128; k++)
				char_maps[m][k] = 8'h00;
		for (int m = MAP_PLAIN; m <= MAP_SHIFT; m++) begin
			char_maps[m][8'h01] = {1'b0, CH_ESC};
			char_maps[m][8'h0E] = 8'h08;
			char_maps[m][8'h0F] = "\t";
			char_maps[m][8'h1C] = "\n";
			char_maps[m][8'h39] = " ";
		end
		lay_keys(MAP_PLAIN, 8'h02, "1234567890'");
		lay_keys(MAP_PLAIN, 8'h10, "qwertyuiop`+");
		lay_keys(MAP_PLAIN, 8'h1E, "asdfghjkln");
		lay_keys(MAP_PLAIN, 8'h2B, "czxcvbnm,.-");
		lay_keys(MAP_PLAIN, 8'h56, "<");
		lay_keys(MAP_SHIFT, 8'h02, "!\"");
		lay_keys(MAP_SHIFT, 8'h05, "$%&/()=?");
		lay_keys(MAP_SHIFT, 8'h10, "QWERTYUIOP^*");
		lay_keys(MAP_SHIFT, 8'h1E, "ASDFGHJKL");
		lay_keys(MAP_SHIFT, 8'h2C, "ZXCVBNM;:_");
		lay_keys(MAP_SHIFT, 8'h56, ">");
		lay_keys(MAP_ALTGR, 8'h02, "|@#~");
		lay_keys(MAP_ALTGR, 8'h1A, "[]");
		lay_keys(MAP_ALTGR, 8'h28, "{\\");
		lay_keys(MAP_ALTGR, 8'h2B, "}");
	endfunction

	// update keyboard state for one taken byte and queue the character it types
	function automatic void translate_byte(input logic [7:0] code);
		logic [6:0] key;
		logic       rel;
		logic       had_prefix;
		logic [7:0] c;
		key = code[6:0];
		rel = code[RELEASE_BIT];
		if (code == PREFIX_BYTE) begin
			kb.prefix_seen = 1'b1;
			return;
		end
		had_prefix = kb.prefix_seen;
		kb.prefix_seen = 1'b0;
		if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
			kb.shift_held = !rel;
		end else if (key == KEY_ALT) begin
			// plain alt is not tracked, only altgr
			if (had_prefix)
				kb.altgr_held = !rel;
		end else if (!rel) begin
			if (key == KEY_CAPS) begin
				kb.caps_on = !kb.caps_on;
			end else begin
				if (kb.altgr_held) begin
					c = char_maps[MAP_ALTGR][key];
				end else if (kb.shift_held) begin
					c = char_maps[MAP_SHIFT][key];
					if (kb.caps_on && c >= "A" && c <= "Z")
						c = c + ("a" - "A");
				end else begin
					c = char_maps[MAP_PLAIN][key];
					if (kb.caps_on && c >= "a" && c <= "z")
						c = c - ("a" - "A");
				end
				if (c != 8'h00)
					expected_chars.push_back(c[6:0]);
			end
		end
	endfunction

	// sender: bursts of bytes with random gaps
	always @(posedge clk) begin : sender
		logic       v;
		logic [7:0] c;
		v = scan_valid;
		c = scan_code;
		if (arst_n) begin
			if (scan_valid && !scan_stall) begin
				translate_byte(scan_code);
				bytes_taken <= bytes_taken + 1;
				v = 1'b0;
			end
			if (!v) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (keystroke_bytes.size() != 0) begin
					c = keystroke_bytes.pop_front();
					v = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
		scan_valid <= v;
		scan_code  <= c;
	end

	// one long hold-off on the character side once traffic is flowing
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_started && bytes_taken >= HOLD_AFTER) begin
			hold_left    <= HOLD_CYCLES;
			hold_started <= 1'b1;
		end
	end

	// receiver: check each character taken, then pick the next stall
	always @(posedge clk) begin : receiver
		logic       s;
		logic [6:0] want;
		s = 1'b0;
		if (arst_n) begin
			if (char_valid && !char_stall) begin
				if (expected_chars.size() == 0) begin
					if (error_count < 10)
						$display("unexpected char 0x%02h", ascii_char);
					error_count++;
				end else begin
					want = expected_chars.pop_front();
					if (ascii_char !== want) begin
						if (error_count < 10)
							$display("char mismatch: expected 0x%02h, got 0x%02h",
								want, ascii_char);
						error_count++;
					end
				end
			end
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end else begin
				mode_left--;
			end
			case (rx_mode)
				RX_FREE:   s = 1'b0;
				RX_LIGHT:  s = ($urandom_range(0, 3) == 0);
				RX_HEAVY:  s = ($urandom_range(0, 3) != 0);
				RX_TOGGLE: s = !char_stall;
				default:   s = 1'b0;
			endcase
			if (hold_left != 0)
				s = 1'b1;
		end
		char_stall <= s;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_scancode_set1_to_ascii: errors");
			$finish;
		end
	end

	// append one byte to the keystroke stream
	function automatic void add_byte(input logic [7:0] b);
		keystroke_bytes.push_back(b);
	endfunction

	initial begin
		logic [7:0] opening [27];
		logic [6:0] k;
		logic       rel;
		logic       altgr_down;
		int         roll;

		build_layout();

		// opening sequence: field extremes, releases, left alt, caps with shift,
		// altgr over caps and shift, prefixed shift release and a doubled prefix
		opening = '{
			8'h00, 8'h1E, 8'hFF, 8'h7F, 8'h80, 8'h9E,
			{1'b0, KEY_ALT}, 8'h1A, {1'b1, KEY_ALT},
			{1'b0, KEY_CAPS}, 8'h1E, {1'b0, KEY_LSHIFT}, 8'h1E,
			PREFIX_BYTE, {1'b0, KEY_ALT}, 8'h02, 8'h1E,
			PREFIX_BYTE, {1'b1, KEY_ALT},
			PREFIX_BYTE, {1'b1, KEY_LSHIFT}, 8'h1E,
			{1'b0, KEY_CAPS}, 8'h56, PREFIX_BYTE, PREFIX_BYTE, 8'h1C
		};
		foreach (opening[i])
			add_byte(opening[i]);

		// random typing: mostly key strokes under changing modifiers, some noise
		altgr_down = 1'b0;
		while (keystroke_bytes.size() < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 55) begin
				if (altgr_down && $urandom_range(0, 1) == 1) begin
					do
						k = 7'($urandom_range(0, 8'h2B));
					while (char_maps[MAP_ALTGR][k] == 8'h00);
				end else if ($urandom_range(0, 4) != 0) begin
					k = 7'($urandom_range(1, 8'h39));
				end else begin
					k = 7'($urandom_range(0, 127));
				end
				add_byte({1'b0, k});
				if ($urandom_range(0, 1) == 1)
					add_byte({1'b1, k});
			end else if (roll < 65) begin
				k = ($urandom_range(0, 1) == 1) ? KEY_LSHIFT : KEY_RSHIFT;
				rel = ($urandom_range(0, 1) == 1);
				if ($urandom_range(0, 6) == 0)
					add_byte(PREFIX_BYTE);
				add_byte({rel, k});
			end else if (roll < 72) begin
				add_byte({1'b0, KEY_CAPS});
				if ($urandom_range(0, 1) == 1)
					add_byte({1'b1, KEY_CAPS});
			end else if (roll < 80) begin
				if ($urandom_range(0, 4) == 0) begin
					// left alt alone
					rel = ($urandom_range(0, 1) == 1);
					add_byte({rel, KEY_ALT});
				end else begin
					rel = altgr_down ? ($urandom_range(0, 9) < 7) : 1'b0;
					add_byte(PREFIX_BYTE);
					add_byte({rel, KEY_ALT});
					altgr_down = !rel;
				end
			end else if (roll < 90) begin
				add_byte(PREFIX_BYTE);
				add_byte(8'($urandom_range(0, 255)));
			end else begin
				add_byte(8'($urandom_range(0, 255)));
			end
		end
		total_bytes = keystroke_bytes.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_taken != total_bytes)
			@(negedge clk);
		while (expected_chars.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (error_count == 0)
			$display("tb_scancode_set1_to_ascii: clean");
		else
			$display("tb_scancode_set1_to_ascii: errors");
		$finish;
	end

endmodule
